// File: rtl/grid_height_interpolator_macros.svh
// assertion macros for the grid height interpolator
// used by the top level, expects clk and arst_n in scope
`ifndef GRID_HEIGHT_INTERPOLATOR_MACROS_SVH
`define GRID_HEIGHT_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define GHI_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GHI_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ghi_pkg.sv
// shared types, codes and widths of the grid height interpolator
// no dependencies
package ghi_pkg;

	localparam int MAX_COLS_DEF = 256;
	localparam int MAX_ROWS_DEF = 256;
	localparam int VW = 32;
	localparam int W = 40;
	localparam int TW = 16;
	localparam int CNTW = 9;
	localparam int IDXW = 12;

	typedef enum logic [1:0] {
		ACT_COL   = 2'd0,
		ACT_ROW   = 2'd1,
		ACT_CELL  = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_NEAREST  = 2'd0,
		MODE_BILINEAR = 2'd1,
		MODE_BICUBIC  = 2'd2,
		MODE_SPARE    = 2'd3
	} mode_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_UNWRITTEN = 2'd2;

	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_COLS = 2'd1;
	localparam logic [1:0] CFG_ROWS = 2'd2;

	typedef struct packed {
		logic busy;
		logic found;
		logic ok1;
		logic ok2;
		logic [IDXW-1:0] idx;
		logic [IDXW-1:0] near;
		logic signed [VW-1:0] lo;
		logic signed [VW-1:0] hi;
	} axis_res_t;

endpackage

// File: rtl/grid_height_interpolator.sv
// grid height interpolator top level: stream ports, config registers and query sequencer
// depends on ghi_pkg, ghi_axis, ghi_cells, ghi_div, ghi_mul and the macros header
//
// usage: one input stream carries writes and queries, tuser selects the action
// (column coordinate, row coordinate, height cell, query). writes give no result;
// a query gives one result transaction on the output stream.
// config registers (mode, column count, row count) are written through cfg_we,
// cfg_addr, cfg_wdata while no query is in flight.
// query: each axis is searched downward from its last coordinate, both axes in
// parallel. then nearest reads one cell; bilinear adds two serial divisions,
// 4 cell reads and 3 shift-add multiplies; bicubic adds the divisions, 16 cell
// reads and 15 multiplies. all multiplies share one multiplier.
// one item is in flight at a time; s_tready is low while a query is worked on.
// after reset the cell valid flags are cleared by a sweep over all
// 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells (65536 at default size) and no input
// is taken meanwhile; config writes are taken.
// a finished result waits in the output register while m_tready is low; the next
// input is still taken, and a later query stalls until the result has gone.
`include "grid_height_interpolator_macros.svh"
module grid_height_interpolator #(
	parameter int MAX_COLS = ghi_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = ghi_pkg::MAX_ROWS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// col_index[7:0], row_index[15:8], write_value[47:16], query_x[79:48], query_y[111:80]
	input  logic [111:0] s_tdata,
	// action[1:0]
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// height[31:0], base_col[39:32], base_row[47:40]
	output logic [47:0] m_tdata,
	// status[1:0]
	output logic [1:0] m_tuser,
	input  logic cfg_we,
	input  logic [1:0] cfg_addr,
	input  logic [ghi_pkg::CNTW-1:0] cfg_wdata
);
	localparam int W = ghi_pkg::W;
	localparam int VW = ghi_pkg::VW;
	localparam int IDXW = ghi_pkg::IDXW;
	localparam int CIW = $clog2(MAX_COLS);
	localparam int RIW = $clog2(MAX_ROWS);
	localparam int CNW = $clog2(MAX_COLS + 1);
	localparam int RNW = $clog2(MAX_ROWS + 1);
	localparam logic signed [W-1:0] SAT_HI = W'(32'sh7FFF_FFFF);
	localparam logic signed [W-1:0] SAT_LO = ~SAT_HI;
	localparam logic signed [W-1:0] ONE_W = W'(1);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_SCAN   = 12'b0000_0000_0010,
		S_CHECK  = 12'b0000_0000_0100,
		S_DSTART = 12'b0000_0000_1000,
		S_DWAIT  = 12'b0000_0001_0000,
		S_FA     = 12'b0000_0010_0000,
		S_FD     = 12'b0000_0100_0000,
		S_COEF   = 12'b0000_1000_0000,
		S_MSTART = 12'b0001_0000_0000,
		S_MWAIT  = 12'b0010_0000_0000,
		S_POST   = 12'b0100_0000_0000,
		S_FIN    = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	ghi_pkg::mode_t mode_q;
	logic [ghi_pkg::CNTW-1:0] ccount_q, rcount_q;
	logic [CNW-1:0] nc;
	logic [RNW-1:0] nr;

	logic [7:0] s_col, s_row;
	logic signed [VW-1:0] s_wv, s_qx, s_qy;
	ghi_pkg::action_t s_action;
	logic s_acc;
	logic signed [VW-1:0] qx_q, qy_q;

	ghi_pkg::axis_res_t xr, yr;
	logic col_we, row_we, cell_we, clearing;
	logic signed [VW-1:0] cell_rd;
	logic cell_ok;
	logic [IDXW-1:0] frow, fcol;

	logic is_bil, is_bic, is_near;
	logic [1:0] klast;

	logic div_start, div_busy;
	logic [VW-1:0] div_num, div_den;
	logic [ghi_pkg::TW-1:0] div_quo, tx_q, ty_q;
	logic dsel_q;
	logic signed [VW:0] dnum, dden;
	ghi_pkg::axis_res_t dr;

	logic mul_start, mul_busy;
	logic signed [W-1:0] mul_prod;

	logic signed [W-1:0] op_q [4];
	logic signed [W-1:0] rows_q [4];
	logic signed [W-1:0] x_q, q_q, r_q, h_q;
	logic signed [W-1:0] cp, cq, cr, res, cell_ext;
	logic [1:0] ph_q, j_q, k_q;
	logic colpass_q, bad_q, fin_step;
	logic [1:0] st_q, st_fin;
	logic [7:0] bc_q, br_q;
	logic signed [W-1:0] h_sat;
	logic fin_load;

	assign s_col = s_tdata[7:0];
	assign s_row = s_tdata[15:8];
	assign s_wv = s_tdata[47:16];
	assign s_qx = s_tdata[79:48];
	assign s_qy = s_tdata[111:80];
	assign s_action = ghi_pkg::action_t'(s_tuser);

	assign s_tready = (state_q == S_IDLE) && !clearing;
	assign s_acc = s_tvalid && s_tready;

	assign nc = (int'(ccount_q) > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(ccount_q);
	assign nr = (int'(rcount_q) > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(rcount_q);

	assign is_bil = (mode_q == ghi_pkg::MODE_BILINEAR);
	assign is_bic = (mode_q == ghi_pkg::MODE_BICUBIC);
	assign is_near = !is_bil && !is_bic;
	assign klast = is_bic ? 2'd3 : (is_bil ? 2'd1 : 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ghi_pkg::MODE_NEAREST;
			ccount_q <= '0;
			rcount_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				ghi_pkg::CFG_MODE: mode_q <= ghi_pkg::mode_t'(cfg_wdata[1:0]);
				ghi_pkg::CFG_COLS: ccount_q <= cfg_wdata;
				ghi_pkg::CFG_ROWS: rcount_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign col_we = s_acc && (s_action == ghi_pkg::ACT_COL) && (int'(s_col) < MAX_COLS);
	assign row_we = s_acc && (s_action == ghi_pkg::ACT_ROW) && (int'(s_row) < MAX_ROWS);
	assign cell_we = s_acc && (s_action == ghi_pkg::ACT_CELL)
		&& (int'(s_col) < MAX_COLS) && (int'(s_row) < MAX_ROWS);

	ghi_axis #(.MAX(MAX_COLS)) u_xaxis (
		.clk(clk), .arst_n(arst_n),
		.wr_en(col_we), .wr_addr(CIW'(s_col)), .wr_data(s_wv),
		.start(s_acc && (s_action == ghi_pkg::ACT_QUERY)),
		.count(nc), .point(qx_q), .res(xr)
	);

	ghi_axis #(.MAX(MAX_ROWS)) u_yaxis (
		.clk(clk), .arst_n(arst_n),
		.wr_en(row_we), .wr_addr(RIW'(s_row)), .wr_data(s_wv),
		.start(s_acc && (s_action == ghi_pkg::ACT_QUERY)),
		.count(nr), .point(qy_q), .res(yr)
	);

	always_comb begin
		if (is_near) begin
			frow = yr.near;
			fcol = xr.near;
		end else begin
			frow = yr.idx - IDXW'(is_bic) + IDXW'(j_q);
			fcol = xr.idx - IDXW'(is_bic) + IDXW'(k_q);
		end
	end

	ghi_cells #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_cells (
		.clk(clk), .arst_n(arst_n),
		.wr_en(cell_we), .wr_addr({RIW'(s_row), CIW'(s_col)}), .wr_data(s_wv),
		.rd_addr({frow[RIW-1:0], fcol[CIW-1:0]}),
		.rd_data(cell_rd), .rd_valid(cell_ok), .clearing(clearing)
	);

	assign dr = dsel_q ? yr : xr;
	assign dnum = {(dsel_q ? qy_q[VW-1] : qx_q[VW-1]), (dsel_q ? qy_q : qx_q)}
		- {dr.lo[VW-1], dr.lo};
	assign dden = {dr.hi[VW-1], dr.hi} - {dr.lo[VW-1], dr.lo};
	assign div_num = dnum[VW-1:0];
	assign div_den = dden[VW-1:0];
	assign div_start = (state_q == S_DSTART);

	ghi_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(div_den), .busy(div_busy), .quo(div_quo)
	);

	assign mul_start = (state_q == S_MSTART);

	ghi_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.x(x_q), .t(colpass_q ? ty_q : tx_q), .busy(mul_busy), .prod(mul_prod)
	);

	// catmull-rom coefficients
	assign cp = op_q[3] - op_q[0] + ((op_q[1] - op_q[2]) <<< 1) + (op_q[1] - op_q[2]);
	assign cq = (op_q[0] <<< 1) - ((op_q[1] <<< 2) + op_q[1]) + (op_q[2] <<< 2) - op_q[3];
	assign cr = op_q[2] - op_q[0];

	assign fin_step = !is_bic || (ph_q == 2'd2);
	assign res = is_bic ? (op_q[1] + ((mul_prod + ONE_W) >>> 1)) : (op_q[0] + mul_prod);
	assign cell_ext = W'(cell_rd);

	assign st_fin = ((st_q == ghi_pkg::ST_OK) && bad_q) ? ghi_pkg::ST_UNWRITTEN : st_q;
	assign h_sat = (h_q > SAT_HI) ? SAT_HI : ((h_q < SAT_LO) ? SAT_LO : h_q);
	assign fin_load = (state_q == S_FIN) && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tuser <= '0;
			qx_q <= '0;
			qy_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
			dsel_q <= 1'b0;
			x_q <= '0;
			q_q <= '0;
			r_q <= '0;
			h_q <= '0;
			ph_q <= '0;
			j_q <= '0;
			k_q <= '0;
			colpass_q <= 1'b0;
			bad_q <= 1'b0;
			st_q <= ghi_pkg::ST_OK;
			bc_q <= '0;
			br_q <= '0;
			for (int i = 0; i < 4; i++) begin
				op_q[i] <= '0;
				rows_q[i] <= '0;
			end
		end else begin
			if (m_tvalid && m_tready && !fin_load) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc && (s_action == ghi_pkg::ACT_QUERY)) begin
						qx_q <= s_qx;
						qy_q <= s_qy;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!xr.busy && !yr.busy) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					bad_q <= 1'b0;
					j_q <= '0;
					k_q <= '0;
					colpass_q <= 1'b0;
					dsel_q <= 1'b0;
					st_q <= ghi_pkg::ST_OK;
					bc_q <= 8'(xr.idx);
					br_q <= 8'(yr.idx);
					if (!is_near && (is_bic ? (xr.ok2 && yr.ok2) : (xr.ok1 && yr.ok1))) begin
						state_q <= S_DSTART;
					end else if (is_near && (nc != '0) && (nr != '0)) begin
						bc_q <= 8'(xr.near);
						br_q <= 8'(yr.near);
						state_q <= S_FA;
					end else begin
						st_q <= ghi_pkg::ST_OUTSIDE;
						bc_q <= '0;
						br_q <= '0;
						state_q <= S_FIN;
					end
				end
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (!div_busy) begin
						if (dsel_q) begin
							ty_q <= div_quo;
							state_q <= S_FA;
						end else begin
							tx_q <= div_quo;
							dsel_q <= 1'b1;
							state_q <= S_DSTART;
						end
					end
				end
				S_FA: state_q <= S_FD;
				S_FD: begin
					op_q[k_q] <= cell_ext;
					bad_q <= bad_q || !cell_ok;
					if (k_q == klast) begin
						if (is_near) begin
							h_q <= cell_ext;
							state_q <= S_FIN;
						end else begin
							state_q <= S_COEF;
						end
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_FA;
					end
				end
				S_COEF: begin
					ph_q <= '0;
					x_q <= is_bic ? cp : (op_q[1] - op_q[0]);
					q_q <= cq;
					r_q <= cr;
					state_q <= S_MSTART;
				end
				S_MSTART: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (!mul_busy) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					if (!fin_step) begin
						x_q <= mul_prod + ((ph_q == 2'd0) ? q_q : r_q);
						ph_q <= ph_q + 1'b1;
						state_q <= S_MSTART;
					end else if (colpass_q) begin
						h_q <= res;
						state_q <= S_FIN;
					end else begin
						rows_q[j_q] <= res;
						if (j_q == klast) begin
							for (int i = 0; i < 4; i++) begin
								op_q[i] <= (2'(i) == j_q) ? res : rows_q[i];
							end
							colpass_q <= 1'b1;
							state_q <= S_COEF;
						end else begin
							j_q <= j_q + 1'b1;
							k_q <= '0;
							state_q <= S_FA;
						end
					end
				end
				S_FIN: begin
					if (fin_load) begin
						m_tvalid <= 1'b1;
						m_tuser <= st_fin;
						m_tdata <= {br_q, bc_q,
							(st_fin == ghi_pkg::ST_OK) ? h_sat[VW-1:0] : {VW{1'b0}}};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`GHI_ASSERT_IMPL(a_no_take_in_clear, s_tready, !clearing, "input taken during cell clear")
	`GHI_ASSERT_NEXT(a_query_scans, s_acc && (s_action == ghi_pkg::ACT_QUERY), state_q == S_SCAN, "query did not start search")
	`GHI_ASSERT_IMPL(a_zero_height, m_tvalid && (m_tuser != ghi_pkg::ST_OK), m_tdata[31:0] == '0, "height not zero on bad status")
	`GHI_ASSERT_IMPL(a_outside_base, m_tvalid && (m_tuser == ghi_pkg::ST_OUTSIDE), m_tdata[47:32] == '0, "base index not zero when outside")

endmodule

// File: rtl/ghi_axis.sv
// one coordinate axis: coordinate memory and downward cell search
// depends on ghi_pkg
module ghi_axis #(
	parameter int MAX = ghi_pkg::MAX_COLS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [$clog2(MAX)-1:0] wr_addr,
	input  logic signed [ghi_pkg::VW-1:0] wr_data,
	input  logic start,
	input  logic [$clog2(MAX+1)-1:0] count,
	input  logic signed [ghi_pkg::VW-1:0] point,
	output ghi_pkg::axis_res_t res
);
	localparam int IW = $clog2(MAX);
	localparam int NW = $clog2(MAX+1);

	typedef enum logic [2:0] {
		A_IDLE = 3'b001,
		A_RD   = 3'b010,
		A_CMP  = 3'b100
	} ast_t;

	logic signed [ghi_pkg::VW-1:0] mem [MAX];
	logic signed [ghi_pkg::VW-1:0] rd_q, lo_q, hi_q;
	logic [IW-1:0] cnt_q, idx_q;
	logic [NW-1:0] n_q;
	logic found_q;
	ast_t st_q;
	logic [NW+1:0] i_ext, n_ext;
	logic signed [ghi_pkg::VW:0] dlo, dhi;
	logic last;
	logic [IW-1:0] near;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= A_IDLE;
			found_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
			n_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
		end else begin
			case (st_q)
				A_IDLE: begin
					if (start) begin
						found_q <= 1'b0;
						n_q <= count;
						if (count != '0) begin
							cnt_q <= IW'(count - 1'b1);
							st_q <= A_RD;
						end
					end
				end
				A_RD: st_q <= A_CMP;
				A_CMP: begin
					if (rd_q <= point) begin
						found_q <= 1'b1;
						idx_q <= cnt_q;
						lo_q <= rd_q;
						st_q <= A_IDLE;
					end else begin
						hi_q <= rd_q;
						if (cnt_q == '0) begin
							st_q <= A_IDLE;
						end else begin
							cnt_q <= cnt_q - 1'b1;
							st_q <= A_RD;
						end
					end
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	assign i_ext = (NW+2)'(idx_q);
	assign n_ext = (NW+2)'(n_q);
	assign last = (i_ext + 2'd1) >= n_ext;
	assign dlo = {point[ghi_pkg::VW-1], point} - {lo_q[ghi_pkg::VW-1], lo_q};
	assign dhi = {hi_q[ghi_pkg::VW-1], hi_q} - {point[ghi_pkg::VW-1], point};

	always_comb begin
		if (!found_q) begin
			near = '0;
		end else if (last) begin
			near = IW'(n_q - 1'b1);
		end else if (dhi < dlo) begin
			near = idx_q + 1'b1;
		end else begin
			near = idx_q;
		end
	end

	assign res.busy = (st_q != A_IDLE);
	assign res.found = found_q;
	assign res.ok1 = found_q && ((i_ext + 2'd1) < n_ext);
	assign res.ok2 = found_q && (idx_q != '0) && ((i_ext + 2'd2) < n_ext);
	assign res.idx = ghi_pkg::IDXW'(idx_q);
	assign res.near = ghi_pkg::IDXW'(near);
	assign res.lo = lo_q;
	assign res.hi = hi_q;

endmodule

// File: rtl/ghi_cells.sv
// height cell memory with valid flag and clearing sweep after reset
// depends on ghi_pkg
module ghi_cells #(
	parameter int MAX_COLS = ghi_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = ghi_pkg::MAX_ROWS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] wr_addr,
	input  logic signed [ghi_pkg::VW-1:0] wr_data,
	input  logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] rd_addr,
	output logic signed [ghi_pkg::VW-1:0] rd_data,
	output logic rd_valid,
	output logic clearing
);
	localparam int AW = $clog2(MAX_ROWS) + $clog2(MAX_COLS);
	localparam int DEPTH = 1 << AW;

	logic [ghi_pkg::VW:0] mem [DEPTH];
	logic [ghi_pkg::VW:0] rd_q;
	logic [AW:0] clr_q;

	assign clearing = !clr_q[AW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_q[AW]) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			mem[clr_q[AW-1:0]] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= {1'b1, wr_data};
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q[ghi_pkg::VW-1:0];
	assign rd_valid = rd_q[ghi_pkg::VW];

endmodule

// File: rtl/ghi_div.sv
// serial restoring divider, one quotient bit per cycle, for the cell fraction
// depends on ghi_pkg
module ghi_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ghi_pkg::VW-1:0] num,
	input  logic [ghi_pkg::VW-1:0] den,
	output logic busy,
	output logic [ghi_pkg::TW-1:0] quo
);
	localparam int CW = $clog2(ghi_pkg::TW + 1);

	logic [ghi_pkg::VW:0] rem_q, sh;
	logic [ghi_pkg::VW-1:0] den_q;
	logic [ghi_pkg::TW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, ge;

	assign sh = {rem_q[ghi_pkg::VW-1:0], 1'b0};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			quo_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(ghi_pkg::TW);
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (sh - {1'b0, den_q}) : sh;
			quo_q <= {quo_q[ghi_pkg::TW-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CW'(1));
		end
	end

	assign busy = busy_q;
	assign quo = quo_q;

endmodule

// File: rtl/ghi_mul.sv
// shift-add multiplier by the Q0.16 fraction with round to nearest, one bit per cycle
// depends on ghi_pkg
module ghi_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [ghi_pkg::W-1:0] x,
	input  logic [ghi_pkg::TW-1:0] t,
	output logic busy,
	output logic signed [ghi_pkg::W-1:0] prod
);
	localparam int AW = ghi_pkg::W + ghi_pkg::TW + 1;
	localparam int CW = $clog2(ghi_pkg::TW + 1);
	localparam logic signed [AW-1:0] HALF = AW'(1) << (ghi_pkg::TW - 1);
	localparam logic signed [AW-1:0] ZERO = '0;

	logic signed [AW-1:0] acc_q, xe, addend, rnd;
	logic signed [ghi_pkg::W-1:0] x_q;
	logic [ghi_pkg::TW-1:0] t_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;

	assign xe = AW'(x_q);
	assign addend = t_q[ghi_pkg::TW-1] ? xe : ZERO;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			acc_q <= '0;
			x_q <= '0;
			t_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(ghi_pkg::TW);
			acc_q <= '0;
			x_q <= x;
			t_q <= t;
		end else if (busy_q) begin
			acc_q <= (acc_q <<< 1) + addend;
			t_q <= {t_q[ghi_pkg::TW-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CW'(1));
		end
	end

	assign rnd = (acc_q + HALF) >>> ghi_pkg::TW;
	assign prod = rnd[ghi_pkg::W-1:0];
	assign busy = busy_q;

endmodule

// File: tb/testbench.sv
// testbench for grid_height_interpolator: directed table then random writes and queries
// predicts most query results in its own model of the grid; depends on ghi_pkg and the rtl
module testbench;
	import ghi_pkg::*;

	typedef struct packed {
		logic [1:0] act;
		logic [7:0] ci;
		logic [7:0] ri;
		logic signed [31:0] wv;
		logic signed [31:0] qx;
		logic signed [31:0] qy;
	} item_t;

	typedef struct packed {
		logic signed [31:0] h;
		logic [1:0] st;
		logic [7:0] bc;
		logic [7:0] br;
	} answer_t;

	typedef struct {
		item_t it;
		bit has_known;
		answer_t known;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [111:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [47:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_we = 0;
	logic [1:0] cfg_addr = '0;
	logic [CNTW-1:0] cfg_wdata = '0;

	grid_height_interpolator u_top (.*);

	always #1 clk = ~clk;

	// predictor copy of the grid
	logic signed [31:0] xs [256];
	logic signed [31:0] ys [256];
	logic signed [31:0] hgt [65536];
	bit hvalid [65536];
	int unsigned mode_r, ncols_r, nrows_r;

	answer_t answers_due [$];
	int fails = 0;
	longint cycles = 0;
	int send_idle = 26, recv_idle = 82;
	bit hold_recv = 0;

	function automatic longint rnd(longint v);
		return (v + 32768) >>> 16;
	endfunction

	function automatic int locate(bit is_col, int n, longint p);
		int f;
		f = -1;
		for (int i = 0; i < n; i++)
			if (longint'(is_col ? xs[i] : ys[i]) <= p) f = i;
		return f;
	endfunction

	function automatic int near_idx(bit is_col, int n, longint p, int i);
		longint dl, dh;
		if (i < 0) return 0;
		if (i >= n - 1) return n - 1;
		dl = p - (is_col ? xs[i] : ys[i]);
		dh = longint'(is_col ? xs[i + 1] : ys[i + 1]) - p;
		return (dh < dl) ? i + 1 : i;
	endfunction

	function automatic longint frac(longint p, longint lo, longint hi);
		longint t;
		if (hi <= lo || p < lo) return 0;
		t = ((p - lo) <<< 16) / (hi - lo);
		return t > 65535 ? 65535 : t;
	endfunction

	function automatic longint blend(longint a, longint b, longint t);
		return a + rnd((b - a) * t);
	endfunction

	function automatic longint cubic(longint a, longint b, longint c, longint d, longint t);
		longint p, q, r, v;
		p = -a + 3 * b - 3 * c + d;
		q = 2 * a - 5 * b + 4 * c - d;
		r = c - a;
		v = rnd(p * t) + q;
		v = rnd(v * t) + r;
		v = rnd(v * t);
		return b + ((v + 1) >>> 1);
	endfunction

	function automatic longint cell_at(int r, int c, ref bit bad);
		if (!hvalid[r * 256 + c]) bad = 1;
		return hgt[r * 256 + c];
	endfunction

	function automatic answer_t predict_height(item_t it);
		answer_t a;
		int nc, nr, ix, iy, bc, br;
		longint h, tx, ty;
		longint rows [4];
		bit bad;
		bc = 0;
		br = 0;
		h = 0;
		bad = 0;
		a.st = ST_OK;
		nc = ncols_r > 256 ? 256 : ncols_r;
		nr = nrows_r > 256 ? 256 : nrows_r;
		ix = locate(1, nc, it.qx);
		iy = locate(0, nr, it.qy);
		if (mode_r == MODE_BILINEAR) begin
			if (ix < 0 || ix + 1 >= nc || iy < 0 || iy + 1 >= nr) begin
				a.st = ST_OUTSIDE;
			end else begin
				tx = frac(it.qx, xs[ix], xs[ix + 1]);
				ty = frac(it.qy, ys[iy], ys[iy + 1]);
				h = blend(blend(cell_at(iy, ix, bad), cell_at(iy, ix + 1, bad), tx),
					blend(cell_at(iy + 1, ix, bad), cell_at(iy + 1, ix + 1, bad), tx), ty);
				bc = ix;
				br = iy;
			end
		end else if (mode_r == MODE_BICUBIC) begin
			if (ix < 1 || ix + 2 >= nc || iy < 1 || iy + 2 >= nr) begin
				a.st = ST_OUTSIDE;
			end else begin
				tx = frac(it.qx, xs[ix], xs[ix + 1]);
				ty = frac(it.qy, ys[iy], ys[iy + 1]);
				for (int j = 0; j < 4; j++)
					rows[j] = cubic(cell_at(iy - 1 + j, ix - 1, bad),
						cell_at(iy - 1 + j, ix, bad), cell_at(iy - 1 + j, ix + 1, bad),
						cell_at(iy - 1 + j, ix + 2, bad), tx);
				h = cubic(rows[0], rows[1], rows[2], rows[3], ty);
				bc = ix;
				br = iy;
			end
		end else begin
			if (nc == 0 || nr == 0) begin
				a.st = ST_OUTSIDE;
			end else begin
				bc = near_idx(1, nc, it.qx, ix);
				br = near_idx(0, nr, it.qy, iy);
				h = cell_at(br, bc, bad);
			end
		end
		if (a.st == ST_OK && bad) a.st = ST_UNWRITTEN;
		if (a.st != ST_OK) begin
			h = 0;
			if (a.st == ST_OUTSIDE) begin
				bc = 0;
				br = 0;
			end
		end
		if (h > 64'sd2147483647) h = 64'sd2147483647;
		if (h < -64'sd2147483648) h = -64'sd2147483648;
		a.h = h[31:0];
		a.bc = bc[7:0];
		a.br = br[7:0];
		return a;
	endfunction

	task automatic apply_item(item_t it);
		case (action_t'(it.act))
			ACT_COL: xs[it.ci] = it.wv;
			ACT_ROW: ys[it.ri] = it.wv;
			ACT_CELL: begin
				hgt[it.ri * 256 + it.ci] = it.wv;
				hvalid[it.ri * 256 + it.ci] = 1;
			end
			default: answers_due.push_back(predict_height(it));
		endcase
	endtask

	task automatic send(item_t it, bit has_known = 0, answer_t known = '0);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= it.act;
		s_tdata <= {it.qy, it.qx, it.wv, it.ri, it.ci};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (has_known) begin
			apply_item(it);
			answers_due[$] = known;
		end else begin
			apply_item(it);
		end
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (answers_due.size() != 0) @(negedge clk);
		repeat (600) @(negedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, int unsigned v);
		s_tvalid <= 0;
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= v[CNTW-1:0];
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			CFG_MODE: mode_r = v & 3;
			CFG_COLS: ncols_r = v & 9'h1ff;
			default: nrows_r = v & 9'h1ff;
		endcase
		@(negedge clk);
	endtask

	function automatic item_t mk(logic [1:0] act, int ci, int ri, int wv, int qx, int qy);
		item_t it;
		it.act = act;
		it.ci = ci[7:0];
		it.ri = ri[7:0];
		it.wv = wv;
		it.qx = qx;
		it.qy = qy;
		return it;
	endfunction

	function automatic int rand32();
		return $urandom();
	endfunction

	// ascending grid of n columns and m rows with random spacing
	task automatic build_grid(int n, int m, int fill);
		int c;
		c = -$urandom_range(40000);
		for (int i = 0; i < n; i++) begin
			send(mk(ACT_COL, i, $urandom, c, rand32(), rand32()));
			c += 1 + $urandom_range(30000);
		end
		c = -$urandom_range(40000);
		for (int i = 0; i < m; i++) begin
			send(mk(ACT_ROW, $urandom, i, c, rand32(), rand32()));
			c += 1 + $urandom_range(30000);
		end
		for (int r = 0; r < m; r++)
			for (int k = 0; k < n; k++)
				if ($urandom_range(99) < fill) begin
					int v;
					v = ($urandom_range(9) == 0) ? rand32() : $signed($urandom_range(2000000)) - 1000000;
					send(mk(ACT_CELL, k, r, v, rand32(), rand32()));
				end
	endtask

	function automatic int axis_point(bit is_col, int n);
		int k;
		if ($urandom_range(9) == 0) return rand32();
		k = $urandom_range(n - 1);
		case ($urandom_range(3))
			0: return is_col ? xs[k] : ys[k];
			1: return (is_col ? xs[k] : ys[k]) - $urandom_range(3);
			default: return (is_col ? xs[k] : ys[k]) + $urandom_range(30000);
		endcase
	endfunction

	// receiver
	always @(negedge clk) begin
		if (hold_recv) m_tready <= 0;
		else m_tready <= !(recv_idle != 0 && $urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		answer_t got, want;
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			got.h = m_tdata[31:0];
			got.bc = m_tdata[39:32];
			got.br = m_tdata[47:40];
			got.st = m_tuser;
			if (answers_due.size() == 0) begin
				fails++;
				if (fails <= 10) $display("unexpected result %h st %0d", m_tdata, m_tuser);
			end else begin
				want = answers_due.pop_front();
				if (got !== want) begin
					fails++;
					if (fails <= 10)
						$display("mismatch: exp h %0d st %0d c %0d r %0d, got h %0d st %0d c %0d r %0d",
							want.h, want.st, want.bc, want.br, got.h, got.st, got.bc, got.br);
				end
			end
		end
		if (cycles > 3000000) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	row_t dir [$];

	initial begin
		int sent;
		answer_t zero_out;
		for (int i = 0; i < 65536; i++) begin
			hgt[i] = 0;
			hvalid[i] = 0;
		end
		for (int i = 0; i < 256; i++) begin
			xs[i] = 0;
			ys[i] = 0;
		end
		mode_r = 0;
		ncols_r = 0;
		nrows_r = 0;
		repeat (12) @(negedge clk);
		arst_n = 1;

		// every coordinate slot written once so full-size counts never hit an empty slot
		for (int i = 0; i < 256; i++) begin
			send(mk(ACT_COL, i, 0, i * 8192 - 1048576, 0, 0));
			send(mk(ACT_ROW, 0, i, i * 8192 - 1048576, 0, 0));
		end

		// directed: empty axes, outside, unwritten, saturation, tie
		zero_out = '{h: 0, st: ST_OUTSIDE, bc: 0, br: 0};
		dir.push_back('{mk(ACT_QUERY, 255, 255, -1, 32'h7fffffff, 32'h80000000), 1, zero_out});
		dir.push_back('{mk(ACT_COL, 0, 255, 0, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_COL, 1, 0, 4096, -1, -1), 0, '0});
		dir.push_back('{mk(ACT_COL, 2, 0, 8192, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_COL, 3, 0, 32'h7fffffff, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_ROW, 0, 0, 32'h80000000, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_ROW, 255, 1, 0, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_ROW, 0, 2, 4096, 0, 0), 0, '0});
		dir.push_back('{mk(ACT_ROW, 0, 3, 8192, 0, 0), 0, '0});
		for (int i = 0; i < 4; i++)
			dir.push_back('{mk(ACT_CELL, i, 1, i[0] ? 32'h7fffffff : 32'h80000000,
				0, 0), 0, '0});
		dir.push_back('{mk(ACT_QUERY, 0, 0, 0, 2048, 2048), 0, '0});
		dir.push_back('{mk(ACT_QUERY, 0, 0, 0, -4096, -4096), 0, '0});
		dir.push_back('{mk(ACT_QUERY, 0, 0, 0, 32'h7fffffff, 32'h7fffffff), 0, '0});

		set_reg(CFG_COLS, 256);
		set_reg(CFG_ROWS, 0);
		foreach (dir[k]) send(dir[k].it, dir[k].has_known, dir[k].known);
		drain();
		set_reg(CFG_COLS, 4);
		set_reg(CFG_ROWS, 4);
		for (int m = 0; m < 4; m++) begin
			set_reg(CFG_MODE, m);
			send(mk(ACT_QUERY, 0, 0, 0, 2048, 2048));
			send(mk(ACT_QUERY, 0, 0, 0, 6000, 5000));
			send(mk(ACT_QUERY, 0, 0, 0, 32'h7fffffff, 0));
			send(mk(ACT_QUERY, 0, 0, 0, 4096, -1));
			drain();
		end

		// random phases
		sent = 0;
		for (int ph = 0; ph < 9; ph++) begin
			int n, m;
			if (ph == 3) begin
				send_idle = 82;
				recv_idle = 26;
			end
			if (ph == 6) begin
				send_idle = 0;
				recv_idle = 0;
			end
			n = 2 + $urandom_range(5);
			m = 2 + $urandom_range(5);
			set_reg(CFG_MODE, $urandom_range(3));
			set_reg(CFG_COLS, (ph == 2) ? 511 : n);
			set_reg(CFG_ROWS, (ph == 5) ? 300 : m);
			build_grid(n, m, 90);
			if (ph == 4) begin
				fork
					begin
						hold_recv = 1;
						repeat (3000) @(negedge clk);
						hold_recv = 0;
					end
					for (int q = 0; q < 6; q++)
						send(mk(ACT_QUERY, 0, 0, 0, axis_point(1, n), axis_point(0, m)));
				join
			end
			for (int q = 0; q < 12; q++) begin
				if ($urandom_range(19) == 0)
					send(mk($urandom_range(2), $urandom, $urandom, rand32(), 0, 0));
				else
					send(mk(ACT_QUERY, $urandom, $urandom, rand32(),
						axis_point(1, n), axis_point(0, m)));
			end
			drain();
		end

		if (fails == 0) $display("testbench: done, clean");
		else $display("testbench: done, errors");
		$finish;
	end
endmodule
